// ===== design/psu_current_limit_regulator_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the current limit regulator core
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PSU_CURRENT_LIMIT_REGULATOR_CORE_MACROS_SVH
`define PSU_CURRENT_LIMIT_REGULATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PCLR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define PCLR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PCLR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PCLR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== design/pclr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pclr_pkg
// Shared constants, codes and types of the current limit regulator core.
// ----------------------------------------------------------------------------
package pclr_pkg;

    // default parameter values
    localparam int ADC_BITS_DEFAULT       = 10;
    localparam int COEF_FRAC_BITS_DEFAULT = 16;

    // fixed field widths
    localparam int COEF_W     = 32;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    localparam int LIMIT_W    = 16;
    localparam int DAC_W      = 8;
    localparam int EVENT_W    = 2;
    localparam int MV_W       = 16;
    localparam int MA_W       = 15;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_LIMIT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_DAC    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VOLT_OFFSET   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VOLT_SLOPE    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IOFF_OFFSET   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IOFF_SLOPE    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_AMP_OFFSET    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_AMP_SLOPE     = 4'd7;

    // register reset values
    localparam logic [LIMIT_W-1:0] CURRENT_LIMIT_RESET = 16'd500;
    localparam logic [DAC_W-1:0]   TARGET_DAC_RESET    = 8'd0;

    // limit event codes
    localparam logic [EVENT_W-1:0] EV_NONE  = 2'd0;
    localparam logic [EVENT_W-1:0] EV_ENTER = 2'd1;
    localparam logic [EVENT_W-1:0] EV_LEAVE = 2'd2;

    // top of the DAC ramp
    localparam logic [DAC_W-1:0] RAMP_TOP = 8'd255;

    // saturation limits
    localparam logic [MV_W-1:0] MV_MAX = 16'hFFFF;
    localparam logic [MA_W-1:0] MA_MAX = 15'h7FFF;

    // coefficient pair select for the shared multiply-add
    typedef logic [1:0] t_sel;
    localparam t_sel SEL_VOLT = 2'd0;
    localparam t_sel SEL_IOFF = 2'd1;
    localparam t_sel SEL_AMP  = 2'd2;

    // configuration register file contents
    typedef struct packed {
        logic        [LIMIT_W-1:0] current_limit_ma;
        logic        [DAC_W-1:0]   target_dac_code;
        logic signed [COEF_W-1:0]  volt_offset;
        logic signed [COEF_W-1:0]  volt_slope;
        logic signed [COEF_W-1:0]  ioff_offset;
        logic signed [COEF_W-1:0]  ioff_slope;
        logic signed [COEF_W-1:0]  amp_offset;
        logic signed [COEF_W-1:0]  amp_slope;
    } t_cfg;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;   // capture input item
        logic mul_en;    // load product register
        t_sel mul_sel;   // slope and operand for the multiplier
        t_sel acc_sel;   // offset added to the product register
        logic cap_mv;    // store saturated millivolts
        logic cap_diff;  // store net current count
        logic load_out;  // update limiter and load output register
    } t_cmd;

endpackage

// ===== design/pclr_sample_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pclr_sample_if
// Input channel: one voltage and one current ADC sample per item.
// ----------------------------------------------------------------------------
interface pclr_sample_if #(
    parameter int ADC_BITS = pclr_pkg::ADC_BITS_DEFAULT
);
    logic                valid;
    logic                ready;
    logic [ADC_BITS-1:0] voltage_sample;
    logic [ADC_BITS-1:0] current_sample;

    modport source (output valid, output voltage_sample, output current_sample, input ready);
    modport sink   (input valid, input voltage_sample, input current_sample, output ready);
endinterface

// ===== design/pclr_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pclr_result_if
// Output channel: DAC code, limiter status and calibrated readings.
// ----------------------------------------------------------------------------
interface pclr_result_if;
    logic                           valid;
    logic                           ready;
    logic [pclr_pkg::DAC_W-1:0]     dac_code;
    logic                           limiting;
    logic [pclr_pkg::EVENT_W-1:0]   limit_event;
    logic [pclr_pkg::MV_W-1:0]      millivolts;
    logic [pclr_pkg::MA_W-1:0]      milliamps;

    modport source (output valid, output dac_code, output limiting, output limit_event,
                    output millivolts, output milliamps, input ready);
    modport sink   (input valid, input dac_code, input limiting, input limit_event,
                    input millivolts, input milliamps, output ready);
endinterface

// ===== design/pclr_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pclr_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface pclr_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [pclr_pkg::CFG_IDX_W-1:0]  index;
    logic [pclr_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/pclr_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pclr_regs
// Configuration register file; writes are registered, unknown indexes drop.
// ----------------------------------------------------------------------------
module pclr_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr_valid,
    input  logic [pclr_pkg::CFG_IDX_W-1:0]  i_wr_index,
    input  logic [pclr_pkg::CFG_DATA_W-1:0] i_wr_data,
    output logic                            o_wr_ready,
    output pclr_pkg::t_cfg                  o_cfg
);

    // register contents after reset
    localparam pclr_pkg::t_cfg CFG_RESET = '{
        current_limit_ma: pclr_pkg::CURRENT_LIMIT_RESET,
        target_dac_code:  pclr_pkg::TARGET_DAC_RESET,
        volt_offset:      '0,
        volt_slope:       '0,
        ioff_offset:      '0,
        ioff_slope:       '0,
        amp_offset:       '0,
        amp_slope:        '0
    };

    pclr_pkg::t_cfg r_cfg;
    pclr_pkg::t_cfg n_cfg;

    assign o_wr_ready = 1'b1;
    assign o_cfg      = r_cfg;

    // write decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_valid) begin
            unique case (i_wr_index)
                pclr_pkg::REG_CURRENT_LIMIT:
                    n_cfg.current_limit_ma = i_wr_data[pclr_pkg::LIMIT_W-1:0];
                pclr_pkg::REG_TARGET_DAC:
                    n_cfg.target_dac_code = i_wr_data[pclr_pkg::DAC_W-1:0];
                pclr_pkg::REG_VOLT_OFFSET: n_cfg.volt_offset = $signed(i_wr_data);
                pclr_pkg::REG_VOLT_SLOPE:  n_cfg.volt_slope  = $signed(i_wr_data);
                pclr_pkg::REG_IOFF_OFFSET: n_cfg.ioff_offset = $signed(i_wr_data);
                pclr_pkg::REG_IOFF_SLOPE:  n_cfg.ioff_slope  = $signed(i_wr_data);
                pclr_pkg::REG_AMP_OFFSET:  n_cfg.amp_offset  = $signed(i_wr_data);
                pclr_pkg::REG_AMP_SLOPE:   n_cfg.amp_slope   = $signed(i_wr_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== design/pclr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pclr_ctrl
// Sequencer for the shared multiply-add and the output register handshake.
// ----------------------------------------------------------------------------
`include "psu_current_limit_regulator_core_macros.svh"

module pclr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output pclr_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_VOLT = 3'd1;  // voltage product
    localparam logic [2:0] S_IOFF = 3'd2;  // millivolts, offset product
    localparam logic [2:0] S_DIFF = 3'd3;  // net current count
    localparam logic [2:0] S_MULA = 3'd4;  // current product
    localparam logic [2:0] S_DONE = 3'd5;  // limiter, output load

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // next state and commands
    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.mul_sel  = pclr_pkg::SEL_VOLT;
        o_cmd.acc_sel  = pclr_pkg::SEL_VOLT;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_VOLT;
                end
            end
            S_VOLT: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = pclr_pkg::SEL_VOLT;
                n_state       = S_IOFF;
            end
            S_IOFF: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = pclr_pkg::SEL_IOFF;
                o_cmd.acc_sel = pclr_pkg::SEL_VOLT;
                o_cmd.cap_mv  = 1'b1;
                n_state       = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.acc_sel  = pclr_pkg::SEL_IOFF;
                o_cmd.cap_diff = 1'b1;
                n_state        = S_MULA;
            end
            S_MULA: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = pclr_pkg::SEL_AMP;
                n_state       = S_DONE;
            end
            S_DONE: begin
                o_cmd.acc_sel = pclr_pkg::SEL_AMP;
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // a finished result never overwrites one that is still waiting
    `PCLR_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, o_cmd.load_out, !r_out_valid || i_out_ready, "result overwritten")
    // loading the output returns the sequencer to idle
    `PCLR_ASSERT_NXT(a_done_idle, i_clk, i_rst_n, o_cmd.load_out, r_state == S_IDLE && r_out_valid, "no idle after load")
    // an accepted item always starts the multiply sequence
    `PCLR_ASSERT_NXT(a_start_seq, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_VOLT, "sequence not started")

endmodule

// ===== design/pclr_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pclr_datapath
// Shared multiply-add with truncation toward zero, saturation and the limiter.
// ----------------------------------------------------------------------------
module pclr_datapath #(
    parameter int ADC_BITS       = pclr_pkg::ADC_BITS_DEFAULT,
    parameter int COEF_FRAC_BITS = pclr_pkg::COEF_FRAC_BITS_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pclr_pkg::t_cmd                i_cmd,
    input  pclr_pkg::t_cfg                i_cfg,
    input  logic [ADC_BITS-1:0]           i_voltage_sample,
    input  logic [ADC_BITS-1:0]           i_current_sample,
    output logic [pclr_pkg::DAC_W-1:0]    o_dac_code,
    output logic                          o_limiting,
    output logic [pclr_pkg::EVENT_W-1:0]  o_limit_event,
    output logic [pclr_pkg::MV_W-1:0]     o_millivolts,
    output logic [pclr_pkg::MA_W-1:0]     o_milliamps
);

    localparam int COEF_W = pclr_pkg::COEF_W;
    localparam int ACC_W  = ADC_BITS + COEF_W + 2;     // offset + sample * slope
    localparam int IOFF_W = ACC_W - COEF_FRAC_BITS;    // integer offset count
    localparam int DIFF_W = IOFF_W + 1;                // sample minus offset
    localparam int P_W    = DIFF_W + COEF_W;           // product
    localparam int SUM_W  = P_W + 1;                   // offset + product

    localparam logic signed [SUM_W-1:0] RND_BIAS =
        SUM_W'((64'd1 << COEF_FRAC_BITS) - 64'd1);
    localparam logic signed [SUM_W-1:0] MV_LIM = SUM_W'(pclr_pkg::MV_MAX);
    localparam logic signed [SUM_W-1:0] MA_LIM = SUM_W'(pclr_pkg::MA_MAX);

    logic [ADC_BITS-1:0]         r_vs;
    logic [ADC_BITS-1:0]         r_is;
    logic signed [P_W-1:0]       r_prod;
    logic signed [DIFF_W-1:0]    r_diff;
    logic                        r_pos;
    logic [pclr_pkg::MV_W-1:0]   r_mv;

    logic                        r_limit_active;
    logic [pclr_pkg::DAC_W-1:0]  r_ramp_level;
    logic                        n_limit_active;
    logic [pclr_pkg::DAC_W-1:0]  n_ramp_level;
    logic [pclr_pkg::EVENT_W-1:0] n_event;
    logic [pclr_pkg::DAC_W-1:0]  n_dac;

    logic [pclr_pkg::DAC_W-1:0]   r_dac_out;
    logic                         r_lim_out;
    logic [pclr_pkg::EVENT_W-1:0] r_ev_out;
    logic [pclr_pkg::MV_W-1:0]    r_mv_out;
    logic [pclr_pkg::MA_W-1:0]    r_ma_out;

    logic signed [DIFF_W-1:0]    mul_x;
    logic signed [COEF_W-1:0]    mul_b;
    logic signed [P_W-1:0]       mul_p;
    logic signed [COEF_W-1:0]    acc_a;
    logic signed [SUM_W-1:0]     acc_sum;
    logic signed [SUM_W-1:0]     acc_bias;
    logic signed [SUM_W-1:0]     acc_tq;
    logic signed [SUM_W-1:0]     is_ext;
    logic signed [SUM_W-1:0]     diff_full;
    logic [pclr_pkg::MV_W-1:0]   mv_sat;
    logic [pclr_pkg::MA_W-1:0]   ma_val;
    logic                        below;

    // multiplier operand select
    always_comb begin
        case (i_cmd.mul_sel)
            pclr_pkg::SEL_VOLT: begin
                mul_x = $signed(DIFF_W'(r_vs));
                mul_b = i_cfg.volt_slope;
            end
            pclr_pkg::SEL_IOFF: begin
                mul_x = $signed(DIFF_W'(r_vs));
                mul_b = i_cfg.ioff_slope;
            end
            default: begin
                mul_x = r_diff;
                mul_b = i_cfg.amp_slope;
            end
        endcase
    end

    assign mul_p = mul_x * mul_b;

    // offset select
    always_comb begin
        case (i_cmd.acc_sel)
            pclr_pkg::SEL_VOLT: acc_a = i_cfg.volt_offset;
            pclr_pkg::SEL_IOFF: acc_a = i_cfg.ioff_offset;
            default:            acc_a = i_cfg.amp_offset;
        endcase
    end

    // add, then drop the fraction rounding toward zero
    assign acc_sum  = SUM_W'(acc_a) + SUM_W'(r_prod);
    assign acc_bias = acc_sum[SUM_W-1] ? (acc_sum + RND_BIAS) : acc_sum;
    assign acc_tq   = acc_bias >>> COEF_FRAC_BITS;

    // millivolt saturation
    always_comb begin
        if (acc_tq[SUM_W-1]) begin
            mv_sat = '0;
        end else if (acc_tq > MV_LIM) begin
            mv_sat = pclr_pkg::MV_MAX;
        end else begin
            mv_sat = acc_tq[pclr_pkg::MV_W-1:0];
        end
    end

    // net current count
    assign is_ext    = $signed(SUM_W'(r_is));
    assign diff_full = is_ext - acc_tq;

    // milliamps; zero when the sample is at or below the offset
    always_comb begin
        if (!r_pos || acc_tq[SUM_W-1]) begin
            ma_val = '0;
        end else if (acc_tq > MA_LIM) begin
            ma_val = pclr_pkg::MA_MAX;
        end else begin
            ma_val = acc_tq[pclr_pkg::MA_W-1:0];
        end
    end

    assign below = {1'b0, ma_val} < i_cfg.current_limit_ma;

    // limiter ramp
    always_comb begin
        n_limit_active = r_limit_active;
        n_ramp_level   = r_ramp_level;
        n_event        = pclr_pkg::EV_NONE;
        if (below) begin
            if (r_limit_active && (r_ramp_level != pclr_pkg::RAMP_TOP)) begin
                n_ramp_level = r_ramp_level + 1'b1;
                if (n_ramp_level >= i_cfg.target_dac_code) begin
                    n_limit_active = 1'b0;
                    n_event        = pclr_pkg::EV_LEAVE;
                end
            end
        end else begin
            if (!r_limit_active) begin
                n_limit_active = 1'b1;
                n_ramp_level   = i_cfg.target_dac_code;
                n_event        = pclr_pkg::EV_ENTER;
            end
            if (n_ramp_level != '0) begin
                n_ramp_level = n_ramp_level - 1'b1;
            end
        end
        n_dac = n_limit_active ? n_ramp_level : i_cfg.target_dac_code;
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_vs <= i_voltage_sample;
            r_is <= i_current_sample;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_p;
        end
        if (i_cmd.cap_mv) begin
            r_mv <= mv_sat;
        end
        if (i_cmd.cap_diff) begin
            r_diff <= diff_full[DIFF_W-1:0];
            r_pos  <= !diff_full[SUM_W-1] && (diff_full != '0);
        end
        if (i_cmd.load_out) begin
            r_dac_out <= n_dac;
            r_lim_out <= n_limit_active;
            r_ev_out  <= n_event;
            r_mv_out  <= r_mv;
            r_ma_out  <= ma_val;
        end
    end

    // limiter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_active <= 1'b0;
            r_ramp_level   <= '0;
        end else if (i_cmd.load_out) begin
            r_limit_active <= n_limit_active;
            r_ramp_level   <= n_ramp_level;
        end
    end

    assign o_dac_code    = r_dac_out;
    assign o_limiting    = r_lim_out;
    assign o_limit_event = r_ev_out;
    assign o_millivolts  = r_mv_out;
    assign o_milliamps   = r_ma_out;

endmodule

// ===== design/psu_current_limit_regulator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_current_limit_regulator_core
// Calibrates voltage and current samples and ramps the DAC code in limiting.
// ----------------------------------------------------------------------------
//  channel   | dir | payload                                          | handshake
//  ----------+-----+--------------------------------------------------+----------
//  i_sample  | in  | voltage_sample, current_sample                   | valid/ready
//  o_result  | out | dac_code, limiting, limit_event, mv, ma          | valid/ready
//  i_cfg     | in  | index, data                                      | valid/ready
//
//  One item at a time: a shared multiplier runs three dependent
//  multiply-adds (voltage, current offset, current) with an extra step for
//  the offset subtraction; the result sits in an output register.
//  The next item is taken while a result waits; the last step holds while
//  the output register is still full. Config writes are always accepted and registered.
//  Reset (synchronous, active low) clears limiting state, sequencer state and config registers.
// ----------------------------------------------------------------------------
module psu_current_limit_regulator_core #(
    parameter int ADC_BITS       = pclr_pkg::ADC_BITS_DEFAULT,
    parameter int COEF_FRAC_BITS = pclr_pkg::COEF_FRAC_BITS_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pclr_sample_if.sink   i_sample,
    pclr_result_if.source o_result,
    pclr_cfg_if.sink      i_cfg
);

    pclr_pkg::t_cfg cfg;
    pclr_pkg::t_cmd cmd;

    // configuration registers
    pclr_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_wr_ready (i_cfg.ready),
        .o_cfg      (cfg)
    );

    // sequencer
    pclr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_sample.valid),
        .o_in_ready  (i_sample.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (cmd)
    );

    // arithmetic and limiter
    pclr_datapath #(
        .ADC_BITS       (ADC_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_cfg            (cfg),
        .i_voltage_sample (i_sample.voltage_sample),
        .i_current_sample (i_sample.current_sample),
        .o_dac_code       (o_result.dac_code),
        .o_limiting       (o_result.limiting),
        .o_limit_event    (o_result.limit_event),
        .o_millivolts     (o_result.millivolts),
        .o_milliamps      (o_result.milliamps)
    );

endmodule

// ===== test/tb_psu_current_limit_regulator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_psu_current_limit_regulator_core
// Self-checking bench for the current limit regulator core. Sample items are
// queued per register setting and driven with random gaps. Each accepted item
// is run through a local calibration and limiter model, and every result item
// is compared field by field, in order, with the oldest predicted reading.
// ----------------------------------------------------------------------------
module tb_psu_current_limit_regulator_core;
    import pclr_pkg::*;

    localparam int ADC_BITS       = ADC_BITS_DEFAULT;
    localparam int COEF_FRAC_BITS = COEF_FRAC_BITS_DEFAULT;
    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 4;
    localparam int SETTLE_CYCLES  = 24;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SHAPED_ITEMS   = 300;
    localparam int NOISE_ITEMS    = 140;

    localparam logic [COEF_W-1:0]    Q_ONE    = 32'h0001_0000;
    localparam logic [COEF_W-1:0]    COEF_MAX = 32'h7FFF_FFFF;
    localparam logic [COEF_W-1:0]    COEF_MIN = 32'h8000_0000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = REG_AMP_SLOPE + 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = '1;

    typedef logic [ADC_BITS-1:0] adc_t;

    typedef struct packed {
        adc_t volt;
        adc_t curr;
    } tick_t;

    typedef struct packed {
        logic [DAC_W-1:0]   dac_code;
        logic               limiting;
        logic [EVENT_W-1:0] limit_event;
        logic [MV_W-1:0]    millivolts;
        logic [MA_W-1:0]    milliamps;
    } reading_t;

    logic i_clk;
    logic i_rst_n;

    pclr_sample_if #(.ADC_BITS(ADC_BITS)) sample_if ();
    pclr_result_if                        result_if ();
    pclr_cfg_if                           cfg_if ();

    psu_current_limit_regulator_core #(
        .ADC_BITS      (ADC_BITS),
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sample(sample_if),
        .o_result(result_if),
        .i_cfg   (cfg_if)
    );

    // local copy of the registers and the limiter state
    t_cfg             reg_model;
    logic             lim_on;
    logic [DAC_W-1:0] ramp_code;

    tick_t    pending_ticks[$];
    reading_t expected_readings[$];

    bit shake          = 1'b1;  // random idling on both channels
    bit sample_fire    = 1'b0;
    int stall_requests = 0;
    int stall_served   = 0;
    int send_gap       = 0;
    int ready_gap      = 0;
    int hold_left      = 0;
    int idle_cycles    = 0;
    int errors         = 0;
    int ticks_checked  = 0;
    int entries_seen   = 0;
    int exits_seen     = 0;
    int settings_run   = 0;

    // trunc(ofs + x*slope) in fixed point, toward zero
    function automatic longint scale_q(logic signed [COEF_W-1:0] ofs,
                                       logic signed [COEF_W-1:0] slope, longint x);
        longint acc;
        acc = longint'(ofs) + x * longint'(slope);
        return acc / (longint'(1) << COEF_FRAC_BITS);
    endfunction

    // net current in mA after offset removal, clamped to the output range
    function automatic longint net_milliamps(adc_t v, adc_t c);
        longint ioff;
        longint ma;
        ioff = scale_q(reg_model.ioff_offset, reg_model.ioff_slope, longint'(v));
        if (longint'(c) <= ioff) return 0;
        ma = scale_q(reg_model.amp_offset, reg_model.amp_slope, longint'(c) - ioff);
        if (ma < 0) return 0;
        if (ma > longint'(MA_MAX)) return longint'(MA_MAX);
        return ma;
    endfunction

    // one control tick: calibrate, then advance the limiter
    function automatic reading_t regulate(tick_t t);
        reading_t r;
        longint   mv;
        longint   ma;
        mv = scale_q(reg_model.volt_offset, reg_model.volt_slope, longint'(t.volt));
        if (mv < 0) begin
            mv = 0;
        end else if (mv > longint'(MV_MAX)) begin
            mv = longint'(MV_MAX);
        end
        ma = net_milliamps(t.volt, t.curr);
        r.limit_event = EV_NONE;
        if (ma < longint'(reg_model.current_limit_ma)) begin
            if (lim_on && ramp_code < RAMP_TOP) begin
                ramp_code = ramp_code + 1'b1;
                if (ramp_code >= reg_model.target_dac_code) begin
                    lim_on        = 1'b0;
                    r.limit_event = EV_LEAVE;
                end
            end
        end else begin
            if (!lim_on) begin
                lim_on        = 1'b1;
                ramp_code     = reg_model.target_dac_code;
                r.limit_event = EV_ENTER;
            end
            if (ramp_code != '0) ramp_code = ramp_code - 1'b1;
        end
        r.dac_code   = lim_on ? ramp_code : reg_model.target_dac_code;
        r.limiting   = lim_on;
        r.millivolts = mv[MV_W-1:0];
        r.milliamps  = ma[MA_W-1:0];
        return r;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_CURRENT_LIMIT: reg_model.current_limit_ma = data[LIMIT_W-1:0];
            REG_TARGET_DAC:    reg_model.target_dac_code  = data[DAC_W-1:0];
            REG_VOLT_OFFSET:   reg_model.volt_offset      = data;
            REG_VOLT_SLOPE:    reg_model.volt_slope       = data;
            REG_IOFF_OFFSET:   reg_model.ioff_offset      = data;
            REG_IOFF_SLOPE:    reg_model.ioff_slope       = data;
            REG_AMP_OFFSET:    reg_model.amp_offset       = data;
            REG_AMP_SLOPE:     reg_model.amp_slope        = data;
            default: ;
        endcase
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 92) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic tick_t random_tick();
        tick_t t;
        t.volt = adc_t'($urandom);
        t.curr = adc_t'($urandom);
        return t;
    endfunction

    // random item on the requested side of the current limit, if one is found
    function automatic tick_t pick_tick(bit over);
        tick_t t;
        t = random_tick();
        for (int n = 0; n < 40; n++) begin
            t = random_tick();
            if ((net_milliamps(t.volt, t.curr) >= longint'(reg_model.current_limit_ma)) == over)
                return t;
        end
        return t;
    endfunction

    // plausible supply calibration
    function automatic t_cfg realistic_cal();
        t_cfg c;
        c.current_limit_ma = CURRENT_LIMIT_RESET;
        c.target_dac_code  = DAC_W'($urandom);
        c.volt_offset      = $urandom_range(0, 32'h0064_0000) - 32'h0032_0000;
        c.volt_slope       = $urandom_range(0, 32'h0050_0000);
        c.ioff_offset      = $urandom_range(0, 32'h0028_0000) - 32'h0014_0000;
        c.ioff_slope       = $urandom_range(0, 32'h0000_4000);
        c.amp_offset       = $urandom_range(0, 32'h00C8_0000) - 32'h0064_0000;
        c.amp_slope        = $urandom_range(32'h0000_8000, 32'h0028_0000);
        return c;
    endfunction

    function automatic logic [COEF_W-1:0] extreme_coef();
        case ($urandom_range(0, 2))
            0:       return COEF_MAX;
            1:       return COEF_MIN;
            default: return '0;
        endcase
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic queue_tick(int v, int c);
        tick_t t;
        t.volt = adc_t'(v);
        t.curr = adc_t'(c);
        pending_ticks.push_back(t);
    endtask

    // one register write over the config channel
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        apply_reg(idx, data);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic program_regs(t_cfg c);
        write_reg(REG_CURRENT_LIMIT, CFG_DATA_W'(c.current_limit_ma));
        write_reg(REG_TARGET_DAC,    CFG_DATA_W'(c.target_dac_code));
        write_reg(REG_VOLT_OFFSET,   c.volt_offset);
        write_reg(REG_VOLT_SLOPE,    c.volt_slope);
        write_reg(REG_IOFF_OFFSET,   c.ioff_offset);
        write_reg(REG_IOFF_SLOPE,    c.ioff_slope);
        write_reg(REG_AMP_OFFSET,    c.amp_offset);
        write_reg(REG_AMP_SLOPE,     c.amp_slope);
        settings_run++;
    endtask

    // limit placed where the calibrated current actually crosses it
    task automatic pick_limit();
        longint ma;
        ma = net_milliamps(adc_t'($urandom), adc_t'($urandom_range(300, 900)));
        write_reg(REG_CURRENT_LIMIT, (ma < 1) ? CFG_DATA_W'(1) : CFG_DATA_W'(ma));
    endtask

    // runs over and under the limit, with noise bursts and broken ramps
    task automatic fill_shaped(int n);
        int left;
        int run;
        left = n;
        while (left > 0) begin
            if ($urandom_range(0, 9) == 0) begin
                run = $urandom_range(1, 5);
                repeat (run) pending_ticks.push_back(random_tick());
                left -= run;
            end else begin
                run = $urandom_range(1, 12);
                repeat (run) pending_ticks.push_back(pick_tick(1'b1));
                left -= run;
                run = $urandom_range(1, int'(reg_model.target_dac_code) + 12);
                repeat (run) pending_ticks.push_back(pick_tick($urandom_range(0, 19) == 0));
                left -= run;
            end
        end
    endtask

    task automatic fill_noise(int n);
        repeat (n) pending_ticks.push_back(random_tick());
    endtask

    // wait until every queued item is in and every result is out
    task automatic settle();
        while (pending_ticks.size() != 0 || sample_if.valid || expected_readings.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // clock
    initial begin : clock_gen
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // sample driver: one item from the queue at a time, random gaps
    always @(negedge i_clk) begin : drive_samples
        tick_t nxt;
        if (!sample_if.valid || sample_fire) begin
            if (send_gap > 0) begin
                send_gap--;
                sample_if.valid <= 1'b0;
            end else if (pending_ticks.size() != 0) begin
                nxt = pending_ticks.pop_front();
                sample_if.valid          <= 1'b1;
                sample_if.voltage_sample <= nxt.volt;
                sample_if.current_sample <= nxt.curr;
                send_gap = shake ? gap_len() : 0;
            end else begin
                sample_if.valid <= 1'b0;
            end
        end
    end

    // result ready: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin : drive_ready
        if (stall_served != stall_requests) begin
            stall_served = stall_requests;
            hold_left    = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            result_if.ready <= 1'b0;
        end else if (!shake) begin
            result_if.ready <= 1'b1;
        end else if (ready_gap > 0) begin
            ready_gap--;
            result_if.ready <= 1'b0;
        end else begin
            result_if.ready <= 1'b1;
            ready_gap = gap_len();
        end
    end

    // monitor: check results, predict accepted items, watchdog
    always @(posedge i_clk) begin : monitor
        reading_t want;
        reading_t got;
        tick_t    seen;
        bit       took_result;
        bit       took_cfg;
        took_result = i_rst_n && result_if.valid && result_if.ready;
        took_cfg    = i_rst_n && cfg_if.valid && cfg_if.ready;
        if (took_result) begin
            got.dac_code    = result_if.dac_code;
            got.limiting    = result_if.limiting;
            got.limit_event = result_if.limit_event;
            got.millivolts  = result_if.millivolts;
            got.milliamps   = result_if.milliamps;
            if (expected_readings.size() == 0) begin
                $display("%0t: result item with nothing expected, expected none, actual %h",
                         $time, got);
                errors++;
            end else begin
                want = expected_readings.pop_front();
                check_field("dac_code",    want.dac_code,    got.dac_code);
                check_field("limiting",    want.limiting,    got.limiting);
                check_field("limit_event", want.limit_event, got.limit_event);
                check_field("millivolts",  want.millivolts,  got.millivolts);
                check_field("milliamps",   want.milliamps,   got.milliamps);
                ticks_checked++;
                if (want.limit_event == EV_ENTER) entries_seen++;
                if (want.limit_event == EV_LEAVE) exits_seen++;
            end
        end
        sample_fire = i_rst_n && sample_if.valid && sample_if.ready;
        if (sample_fire) begin
            seen.volt = sample_if.voltage_sample;
            seen.curr = sample_if.current_sample;
            expected_readings.push_back(regulate(seen));
        end
        if (took_result || took_cfg || sample_fire) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no item accepted for %0d cycles", $time, idle_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial begin : main
        t_cfg c;
        i_rst_n                  = 1'b0;
        sample_if.valid          = 1'b0;
        sample_if.voltage_sample = '0;
        sample_if.current_sample = '0;
        result_if.ready          = 1'b0;
        cfg_if.valid             = 1'b0;
        cfg_if.index             = '0;
        cfg_if.data              = '0;
        reg_model                  = '0;
        reg_model.current_limit_ma = CURRENT_LIMIT_RESET;
        reg_model.target_dac_code  = TARGET_DAC_RESET;
        lim_on    = 1'b0;
        ramp_code = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: zero calibration, default limit
        queue_tick(0, 0);
        queue_tick(1023, 1023);
        settle();

        // unity current scale, small target to reach the ramp floor quickly
        c                  = '0;
        c.current_limit_ma = 16'd500;
        c.target_dac_code  = 8'd3;
        c.volt_slope       = 32'h0002_0000;
        c.amp_slope        = Q_ONE;
        program_regs(c);
        queue_tick(0, 0);
        queue_tick(1023, 1023);   // enter, ramp steps down from target
        queue_tick(1023, 600);
        queue_tick(512, 500);     // exactly at the limit still limits
        queue_tick(0, 1023);      // held at the floor
        queue_tick(0, 499);       // ramp back up
        queue_tick(1023, 0);
        queue_tick(0, 100);       // reaches target, leaves
        settle();

        // zero target on entry
        write_reg(REG_TARGET_DAC, CFG_DATA_W'(0));
        queue_tick(100, 800);
        queue_tick(100, 800);
        queue_tick(100, 10);
        settle();

        // target lowered while limiting
        write_reg(REG_TARGET_DAC, CFG_DATA_W'(200));
        queue_tick(300, 900);
        queue_tick(300, 900);
        settle();
        write_reg(REG_TARGET_DAC, CFG_DATA_W'(50));
        queue_tick(300, 20);
        settle();

        // top target: ramp never sits at the top while limiting
        write_reg(REG_TARGET_DAC, CFG_DATA_W'(RAMP_TOP));
        queue_tick(5, 1000);
        queue_tick(5, 5);
        settle();

        // negative offset of -1.5 counts truncates to -1
        write_reg(REG_IOFF_OFFSET, 32'hFFFE_8000);
        queue_tick(0, 0);
        settle();
        // positive offset: at or below it the net current is zero
        write_reg(REG_IOFF_OFFSET, 32'h00C8_0000);
        queue_tick(7, 150);
        queue_tick(7, 200);
        queue_tick(7, 201);
        settle();

        // writes beyond the last register change nothing
        write_reg(REG_UNUSED_LO, $urandom);
        write_reg(REG_UNUSED_HI, $urandom);
        queue_tick(1023, 1023);
        settle();

        // extreme coefficients: saturation high, then clamp low
        c             = '0;
        c.volt_offset = COEF_MAX;
        c.volt_slope  = COEF_MAX;
        c.amp_slope   = COEF_MAX;
        program_regs(c);
        queue_tick(1023, 1023);
        settle();
        c.volt_slope = COEF_MIN;
        c.amp_slope  = COEF_MIN;
        c.ioff_slope = COEF_MAX;
        c.amp_offset = COEF_MIN;
        program_regs(c);
        queue_tick(1023, 1023);
        settle();

        // random part, one register setting per phase
        for (int p = 0; p < 8; p++) begin
            shake = 1'b1;
            case (p)
                0, 6: begin
                    program_regs(realistic_cal());
                    pick_limit();
                    fill_shaped(SHAPED_ITEMS);
                end
                1: begin
                    // back-to-back items into a long result stall
                    shake = 1'b0;
                    program_regs(realistic_cal());
                    pick_limit();
                    fill_shaped(SHAPED_ITEMS);
                    stall_requests++;
                end
                2: begin
                    c.current_limit_ma = LIMIT_W'($urandom);
                    c.target_dac_code  = DAC_W'($urandom);
                    c.volt_offset      = $urandom;
                    c.volt_slope       = $urandom;
                    c.ioff_offset      = $urandom;
                    c.ioff_slope       = $urandom;
                    c.amp_offset       = $urandom;
                    c.amp_slope        = $urandom;
                    program_regs(c);
                    fill_noise(NOISE_ITEMS);
                end
                3: begin
                    // zero limit: always limiting, ramp only steps down
                    c                  = realistic_cal();
                    c.current_limit_ma = '0;
                    c.target_dac_code  = RAMP_TOP;
                    program_regs(c);
                    fill_noise(NOISE_ITEMS);
                end
                4: begin
                    // highest limit: never reached
                    c                  = realistic_cal();
                    c.current_limit_ma = '1;
                    c.target_dac_code  = '0;
                    program_regs(c);
                    fill_noise(NOISE_ITEMS);
                end
                5: begin
                    c.current_limit_ma = LIMIT_W'($urandom);
                    c.target_dac_code  = DAC_W'($urandom);
                    c.volt_offset      = extreme_coef();
                    c.volt_slope       = extreme_coef();
                    c.ioff_offset      = extreme_coef();
                    c.ioff_slope       = extreme_coef();
                    c.amp_offset       = extreme_coef();
                    c.amp_slope        = extreme_coef();
                    program_regs(c);
                    fill_shaped(NOISE_ITEMS);
                end
                default: begin
                    program_regs(realistic_cal());
                    pick_limit();
                    fill_shaped(SHAPED_ITEMS);
                    stall_requests++;
                end
            endcase
            // sender pauses here until every result is back
            settle();
        end

        if (expected_readings.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_readings.size());
            errors++;
        end
        $display("Checked %0d result items over %0d register settings.", ticks_checked,
                 settings_run);
        $display("Limiting entered %0d times and left %0d times, with random and long stalls.",
                 entries_seen, exits_seen);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/pclr_pkg.sv
design/pclr_sample_if.sv
design/pclr_result_if.sv
design/pclr_cfg_if.sv
design/pclr_regs.sv
design/pclr_ctrl.sv
design/pclr_datapath.sv
design/psu_current_limit_regulator_core.sv
test/tb_psu_current_limit_regulator_core.sv
